/* design/aesbc_pkg.sv */
package aesbc_pkg;

    typedef struct packed {
        logic        func;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_item;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_w(input logic [31:0] w);
        sub_w = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

endpackage

/* design/aesbc_key_cell.sv */
// one word of the key-schedule window; words shift one place per step
module aesbc_key_cell (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_load_word,
    input  logic        i_shift,
    input  logic [31:0] i_word,
    output logic [31:0] o_word
);
    logic [31:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_load_word;
        end else if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;
endmodule

/* design/aesbc_col_cell.sv */
// one state column; forward or inverse round step on the column
// the column receives its shifted-row bytes from its neighbors
module aesbc_col_cell (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_load_col,
    input  logic        i_step,
    input  logic        i_inv,
    input  logic        i_last,
    input  logic [31:0] i_shifted,
    input  logic [31:0] i_rkey,
    output logic [31:0] o_col
);
    logic [31:0] r_col;
    logic [7:0]  s0, s1, s2, s3;
    logic [7:0]  a0, a1, a2, a3;
    logic [31:0] fm, im, n_col;
    logic [7:0]  x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;

    always_comb begin
        s0 = i_inv ? aesbc_pkg::INV_BOX[i_shifted[31:24]] : aesbc_pkg::FWD_BOX[i_shifted[31:24]];
        s1 = i_inv ? aesbc_pkg::INV_BOX[i_shifted[23:16]] : aesbc_pkg::FWD_BOX[i_shifted[23:16]];
        s2 = i_inv ? aesbc_pkg::INV_BOX[i_shifted[15:8]]  : aesbc_pkg::FWD_BOX[i_shifted[15:8]];
        s3 = i_inv ? aesbc_pkg::INV_BOX[i_shifted[7:0]]   : aesbc_pkg::FWD_BOX[i_shifted[7:0]];
        x0 = aesbc_pkg::xt(s0); x1 = aesbc_pkg::xt(s1);
        x2 = aesbc_pkg::xt(s2); x3 = aesbc_pkg::xt(s3);
        fm = {x0 ^ x1 ^ s1 ^ s2 ^ s3, s0 ^ x1 ^ x2 ^ s2 ^ s3,
              s0 ^ s1 ^ x2 ^ x3 ^ s3, x0 ^ s0 ^ s1 ^ s2 ^ x3};
        // inverse: add key first, then inverse mix
        a0 = s0 ^ i_rkey[31:24]; a1 = s1 ^ i_rkey[23:16];
        a2 = s2 ^ i_rkey[15:8];  a3 = s3 ^ i_rkey[7:0];
        x0 = aesbc_pkg::xt(a0); x1 = aesbc_pkg::xt(a1);
        x2 = aesbc_pkg::xt(a2); x3 = aesbc_pkg::xt(a3);
        y0 = aesbc_pkg::xt(x0); y1 = aesbc_pkg::xt(x1);
        y2 = aesbc_pkg::xt(x2); y3 = aesbc_pkg::xt(x3);
        z0 = aesbc_pkg::xt(y0); z1 = aesbc_pkg::xt(y1);
        z2 = aesbc_pkg::xt(y2); z3 = aesbc_pkg::xt(y3);
        // 0e = 8^4^2, 0b = 8^2^1, 0d = 8^4^1, 09 = 8^1
        im = {(z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3),
              (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3),
              (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3),
              (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3)};
        if (i_last) begin
            n_col = {s0, s1, s2, s3} ^ i_rkey;
        end else if (i_inv) begin
            n_col = im;
        end else begin
            n_col = fm ^ i_rkey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col <= i_load_col;
        end else if (i_step) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;
endmodule

/* design/aes_block_cipher_unit.sv */
// one item at a time: a new item is taken only once the last has finished its rounds
//   (nr = 10, 12 or 14 rounds for 128-, 192- and 256-bit keys), set by the
//   single round unit of four column cells iterating once per round
// key expansion after a key-size or key-word write outside a run: one word per cycle
//   for 44/52/60 words, the input stalls meanwhile; key store holds 15 round keys of 128 bits
// reset: synchronous active low, clears control and key registers
module aes_block_cipher_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  aesbc_pkg::t_in_item   i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output aesbc_pkg::t_out_item  o_item
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       r_ks;
    logic [63:0]      r_kw [4];
    logic [5:0]       r_i;       // expansion word index
    logic [2:0]       r_mod;     // i mod nk
    logic [7:0]       r_rc;
    logic [3:0]       r_rnd;
    logic             r_inv;
    logic             r_out_v;
    logic             r_cap;     // finished item waiting in the column cells
    logic [127:0]     r_out;
    logic [3:0][31:0] r_mem [15];  // one round key per entry, column c in slot c
    logic [31:0]      r_rk   [4];
    logic [3:0]       nk;
    logic [2:0]       nk_m1, woff, kj;
    logic [3:0]       nr;
    logic [31:0]      win [8];
    logic [31:0]      t, new_w, key_w, load_w [8];
    logic             kload, kshift, cfg_go;
    logic [31:0]      cols [4];
    logic [31:0]      shf  [4];
    logic             cload, cstep, clast;
    logic [127:0]     blk, fin;
    logic [31:0]      rk_now [4];
    logic [3:0]       next_rnd;
    logic             accept, fin_go;

    always_comb begin
        case (r_ks)
            aesbc_pkg::KS_128: begin nk = 4'd4; nr = 4'd10; end
            aesbc_pkg::KS_192: begin nk = 4'd6; nr = 4'd12; end
            default:           begin nk = 4'd8; nr = 4'd14; end // size three acts as 256
        endcase
        nk_m1 = 3'(nk - 4'd1);
        woff  = 3'(4'd8 - nk);
    end

    // key window: eight chained cells, oldest word at index 0
    genvar g;
    generate
        for (g = 0; g < 8; g++) begin : g_key
            aesbc_key_cell u_kc (
                .i_clk(i_clk), .i_load(kload), .i_load_word(load_w[g]),
                .i_shift(kshift), .i_word((g == 7) ? new_w : win[(g + 1) % 8]),
                .o_word(win[g])
            );
        end
    endgenerate

    always_comb begin
        // key words sit right-aligned so the last one lands at index 7
        for (int k = 0; k < 8; k++) begin
            kj = 3'(k) - woff;
            load_w[k] = kj[0] ? r_kw[kj[2:1]][31:0] : r_kw[kj[2:1]][63:32];
        end
        key_w = r_i[0] ? r_kw[r_i[2:1]][31:0] : r_kw[r_i[2:1]][63:32];
        t = win[7];
        if (r_mod == 3'd0) begin
            t = aesbc_pkg::sub_w({t[23:0], t[31:24]}) ^ {r_rc, 24'h0};
        end else if (r_ks != aesbc_pkg::KS_128 && r_ks != aesbc_pkg::KS_192
                     && r_mod == 3'd4) begin
            t = aesbc_pkg::sub_w(t);
        end
        // word i-nk sits at window index 8-nk
        new_w = win[woff] ^ t;
    end

    assign cfg_go = i_cfg_we && i_cfg_idx <= aesbc_pkg::REG_KEY_W3;
    assign kload  = (r_state == ST_EXP) && (r_i == 6'd0);
    assign kshift = (r_state == ST_EXP) && (r_i >= {2'd0, nk});

    // block in: columns
    assign blk = {i_item.block_hi, i_item.block_lo};
    assign accept = i_valid && !o_stall;
    // a finished item may wait in the cells while the output register is full
    assign o_stall = (r_state != ST_IDLE) || (r_cap && r_out_v);
    assign fin_go  = r_cap && (!r_out_v || !i_stall);

    // round key for the next step is held in a register
    assign next_rnd = r_inv ? r_rnd - 4'd1 : r_rnd + 4'd1;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            rk_now[c] = r_rk[c];
        end
    end

    assign cload = accept;
    assign cstep = (r_state == ST_RUN);
    assign clast = r_inv ? (r_rnd == 4'd0) : (r_rnd == nr);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shf[c][31 - 8*r -: 8] = r_inv ? cols[(c + 4 - r) & 3][31 - 8*r -: 8]
                                              : cols[(c + r) & 3][31 - 8*r -: 8];
            end
        end
    end

    generate
        for (g = 0; g < 4; g++) begin : g_col
            aesbc_col_cell u_cc (
                .i_clk(i_clk), .i_load(cload),
                .i_load_col(blk[127 - 32*g -: 32] ^ (i_item.func ?
                             r_mem[nr][g] : r_mem[4'd0][g])),
                .i_step(cstep), .i_inv(r_inv), .i_last(clast),
                .i_shifted(shf[g]), .i_rkey(rk_now[g]), .o_col(cols[g])
            );
        end
    endgenerate

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            fin[127 - 32*c -: 32] = cols[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXP) begin
            r_mem[r_i[5:2]][r_i[1:0]] <= (r_i < {2'd0, nk}) ? key_w : new_w;
        end
        for (int c = 0; c < 4; c++) begin
            if (accept) begin
                r_rk[c] <= r_mem[i_item.func ? nr - 4'd1 : 4'd1][c];
            end else if (r_state == ST_RUN && !clast) begin
                r_rk[c] <= r_mem[next_rnd][c];
            end
        end
        if (accept) begin
            r_inv <= i_item.func;
        end
        if (fin_go) begin
            r_out <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ks    <= 2'd0;
            r_out_v <= 1'b0;
            r_i     <= 6'd0;
            r_mod   <= 3'd0;
            r_rc    <= aesbc_pkg::RCON_FIRST;
            r_rnd   <= 4'd0;
            for (int k = 0; k < 4; k++) begin
                r_kw[k] <= 64'h0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == aesbc_pkg::REG_KEY_SIZE) begin
                r_ks <= i_cfg_data[1:0];
            end else if (i_cfg_we && i_cfg_idx >= aesbc_pkg::REG_KEY_W0
                         && i_cfg_idx <= aesbc_pkg::REG_KEY_W3) begin
                r_kw[2'(i_cfg_idx - aesbc_pkg::REG_KEY_W0)] <= i_cfg_data;
            end
            if (fin_go) begin
                r_out_v <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (cfg_go) begin
                        r_state <= ST_EXP;
                        r_i     <= 6'd0;
                        r_mod   <= 3'd0;
                        r_rc    <= aesbc_pkg::RCON_FIRST;
                    end else if (accept) begin
                        r_state <= ST_RUN;
                        r_rnd   <= i_item.func ? nr - 4'd1 : 4'd1;
                    end
                end
                ST_EXP: begin
                    if (cfg_go) begin
                        // another key write starts the schedule over
                        r_i   <= 6'd0;
                        r_mod <= 3'd0;
                        r_rc  <= aesbc_pkg::RCON_FIRST;
                    end else begin
                        // window holds the key until i reaches nk, then slides
                        r_i <= r_i + 6'd1;
                        if (kshift) begin
                            r_mod <= (r_mod == nk_m1) ? 3'd0 : r_mod + 3'd1;
                            if (r_mod == 3'd0) begin
                                r_rc <= aesbc_pkg::xt(r_rc);
                            end
                        end
                        if (r_i == {nr, 2'b11}) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_RUN: begin
                    r_rnd <= next_rnd;
                    if (clast) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result moves from the column cells to the output register once it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b0;
        end else if ((r_state == ST_RUN) && clast) begin
            r_cap <= 1'b1;
        end else if (fin_go) begin
            r_cap <= 1'b0;
        end
    end

    assign o_valid = r_out_v;
    assign o_item.result_hi = r_out[127:64];
    assign o_item.result_lo = r_out[63:0];

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept)
        else $error("item taken while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && clast) |=> r_cap)
        else $error("finished item not kept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled result changed");
endmodule
